// ===== design/life_pkg.sv =====
// life_pkg: shared widths, codes, word types and controller/datapath links
// for the toroidal life grid block
// no dependencies
`default_nettype none

package life_pkg;

  // field widths fixed by the word formats
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 5;
  localparam int ROWN_W     = 5;
  localparam int CELLS_W    = 32;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int NBR_W      = 4;

  // default grid limits
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  // size registers after reset
  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd30;

  // b3/s23 rule
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  // item functions
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DUMP = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  // grid read address selection
  localparam int RD_SEL_W = 3;
  localparam logic [RD_SEL_W-1:0] RD_LAST  = 3'd0;
  localparam logic [RD_SEL_W-1:0] RD_ZERO  = 3'd1;
  localparam logic [RD_SEL_W-1:0] RD_NEXT  = 3'd2;
  localparam logic [RD_SEL_W-1:0] RD_NEXT2 = 3'd3;
  localparam logic [RD_SEL_W-1:0] RD_CELL  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
  } item_word_t;

  typedef struct packed {
    logic [ROWN_W-1:0]  row_number;
    logic [CELLS_W-1:0] row_cells;
    logic               last_row;
  } result_word_t;

  typedef struct packed {
    logic                latch_item;
    logic                rd_en;
    logic [RD_SEL_W-1:0] rd_sel;
    logic                clr_row;
    logic                load_prev;
    logic                load_cur;
    logic                gen_row;
    logic                dump_row;
    logic                cell_write;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_range;
    logic              has_next;
    logic              has_next2;
    logic              last;
    logic              out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/life_ram.sv =====
// life_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module life_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/life_ctrl.sv =====
// life_ctrl: sequencer for cell writes, generation steps and grid dumps
// depends on life_pkg
`default_nettype none

module life_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  output life_pkg::dp_cmd_t         cmd,
  input  wire life_pkg::dp_status_t status
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECODE  = 3'd1;
  localparam logic [2:0] ST_CELL_WR = 3'd2;
  localparam logic [2:0] ST_GEN_P1  = 3'd3;
  localparam logic [2:0] ST_GEN_P2  = 3'd4;
  localparam logic [2:0] ST_GEN     = 3'd5;
  localparam logic [2:0] ST_DUMP    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = life_pkg::RD_ZERO;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clr_row = 1'b1;
        case (status.func)
          life_pkg::FUNC_SET, life_pkg::FUNC_CLR: begin
            if (status.in_range) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = life_pkg::RD_CELL;
              state_next = ST_CELL_WR;
            end else begin
              state_next = ST_IDLE;
            end
          end
          life_pkg::FUNC_STEP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = life_pkg::RD_LAST;
            state_next = ST_GEN_P1;
          end
          default: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = life_pkg::RD_ZERO;
            state_next = ST_DUMP;
          end
        endcase
      end
      ST_CELL_WR: begin
        cmd.cell_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_GEN_P1: begin
        cmd.load_prev = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = life_pkg::RD_ZERO;
        state_next    = ST_GEN_P2;
      end
      ST_GEN_P2: begin
        cmd.load_cur = 1'b1;
        cmd.rd_en    = status.has_next;
        cmd.rd_sel   = life_pkg::RD_NEXT;
        state_next   = ST_GEN;
      end
      ST_GEN: begin
        if (status.out_free) begin
          cmd.gen_row = 1'b1;
          cmd.rd_en   = status.has_next2;
          cmd.rd_sel  = life_pkg::RD_NEXT2;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DUMP: begin
        if (status.out_free) begin
          cmd.dump_row = 1'b1;
          cmd.rd_en    = status.has_next;
          cmd.rd_sel   = life_pkg::RD_NEXT;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/life_dpath.sv =====
// life_dpath: size registers, grid ram with row valid bits, three-row window,
// row-wide rule evaluation and result register
// depends on life_pkg and life_ram
`default_nettype none

module life_dpath #(
  parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [life_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [life_pkg::CFG_W-1:0]            cfg_data,
  input  wire life_pkg::item_word_t                  item,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output life_pkg::result_word_t                     result,
  input  wire life_pkg::dp_cmd_t                     cmd,
  output life_pkg::dp_status_t                       status
);

  localparam int RW      = $clog2(MAX_ROWS);
  localparam int CW      = $clog2(MAX_COLS);
  localparam int CFG_W   = life_pkg::CFG_W;
  localparam int CFG_XW  = CFG_W + 1;
  localparam int NBR_W   = life_pkg::NBR_W;
  localparam int ROWN_W  = life_pkg::ROWN_W;
  localparam int CELLS_W = life_pkg::CELLS_W;

  logic [CFG_W-1:0]     row_count;
  logic [CFG_W-1:0]     col_count;
  life_pkg::item_word_t item_q;

  logic [CFG_XW-1:0]    rows_wide;
  logic [CFG_XW-1:0]    cols_wide;
  logic [RW:0]          rows_sz;
  logic [CW:0]          cols_sz;
  logic [RW:0]          rows_m1;
  logic [CW:0]          cols_m1;
  logic [CW-1:0]        col_last;

  logic [RW-1:0]        row_idx;
  logic [RW-1:0]        rd_addr;
  logic [RW-1:0]        cell_row;
  logic [RW-1:0]        wr_addr;
  logic                 wr_en;
  logic [MAX_COLS-1:0]  wr_data;
  logic [MAX_COLS-1:0]  ram_q;
  logic [MAX_ROWS-1:0]  row_valid;
  logic                 rd_valid;
  logic [MAX_COLS-1:0]  rd_row;

  logic [MAX_COLS-1:0]  prev_row;
  logic [MAX_COLS-1:0]  cur_row;
  logic [MAX_COLS-1:0]  first_row;
  logic [MAX_COLS-1:0]  nxt_row;
  logic [MAX_COLS-1:0]  life_row;
  logic [MAX_COLS-1:0]  col_mask;
  logic [MAX_COLS-1:0]  merged_row;
  logic [MAX_COLS-1:0]  cell_bit;
  logic [MAX_COLS-1:0]  cell_new;
  logic [MAX_COLS-1:0]  emit_row;

  logic [MAX_COLS-1:0]  pw, pe, cw, ce, nw, ne;

  function automatic logic [MAX_COLS-1:0] from_west(input logic [MAX_COLS-1:0] v,
                                                    input logic [CW-1:0] lastc);
    return {v[MAX_COLS-2:0], v[lastc]};
  endfunction

  function automatic logic [MAX_COLS-1:0] from_east(input logic [MAX_COLS-1:0] v,
                                                    input logic [CW-1:0] lastc);
    logic [MAX_COLS-1:0] e;
    e        = {v[0], v[MAX_COLS-1:1]};
    e[lastc] = v[0];
    return e;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= life_pkg::SIZE_RESET;
      col_count <= life_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        life_pkg::REG_ROW_COUNT: row_count <= cfg_data;
        life_pkg::REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // size clamping: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (row_count == '0) begin
      rows_wide = CFG_XW'(1);
    end else if ({1'b0, row_count} > CFG_XW'(MAX_ROWS)) begin
      rows_wide = CFG_XW'(MAX_ROWS);
    end else begin
      rows_wide = {1'b0, row_count};
    end
    if (col_count == '0) begin
      cols_wide = CFG_XW'(1);
    end else if ({1'b0, col_count} > CFG_XW'(MAX_COLS)) begin
      cols_wide = CFG_XW'(MAX_COLS);
    end else begin
      cols_wide = {1'b0, col_count};
    end
  end

  assign rows_sz  = rows_wide[RW:0];
  assign cols_sz  = cols_wide[CW:0];
  assign rows_m1  = rows_sz - (RW+1)'(1);
  assign cols_m1  = cols_sz - (CW+1)'(1);
  assign col_last = cols_m1[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx <= '0;
    end else if (cmd.clr_row) begin
      row_idx <= '0;
    end else if (cmd.gen_row || cmd.dump_row) begin
      row_idx <= row_idx + RW'(1);
    end
  end

  assign cell_row = RW'(item_q.row_index);

  always_comb begin
    case (cmd.rd_sel)
      life_pkg::RD_LAST:  rd_addr = rows_m1[RW-1:0];
      life_pkg::RD_ZERO:  rd_addr = '0;
      life_pkg::RD_NEXT:  rd_addr = row_idx + RW'(1);
      life_pkg::RD_NEXT2: rd_addr = row_idx + RW'(2);
      life_pkg::RD_CELL:  rd_addr = cell_row;
      default:            rd_addr = '0;
    endcase
  end

  // grid store; rows never written since reset read as dead
  life_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_valid ? ram_q : '0;

  // cell write
  assign cell_bit = {{(MAX_COLS-1){1'b0}}, 1'b1} << CW'(item_q.col_index);
  assign cell_new = (item_q.func == life_pkg::FUNC_SET) ? (rd_row | cell_bit)
                                                        : (rd_row & ~cell_bit);

  // three-row window
  assign nxt_row = status.last ? first_row : rd_row;

  always_ff @(posedge clk) begin
    if (cmd.load_prev) begin
      prev_row <= rd_row;
    end else if (cmd.gen_row) begin
      prev_row <= cur_row;
    end
    if (cmd.load_cur) begin
      cur_row   <= rd_row;
      first_row <= rd_row;
    end else if (cmd.gen_row) begin
      cur_row <= nxt_row;
    end
  end

  // rule evaluation across the whole row
  assign pw = from_west(prev_row, col_last);
  assign pe = from_east(prev_row, col_last);
  assign cw = from_west(cur_row,  col_last);
  assign ce = from_east(cur_row,  col_last);
  assign nw = from_west(nxt_row,  col_last);
  assign ne = from_east(nxt_row,  col_last);

  always_comb begin
    logic [NBR_W-1:0] nbr;
    nbr      = '0;
    life_row = '0;
    col_mask = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      nbr = NBR_W'(pw[c]) + NBR_W'(prev_row[c]) + NBR_W'(pe[c])
          + NBR_W'(cw[c]) + NBR_W'(ce[c])
          + NBR_W'(nw[c]) + NBR_W'(nxt_row[c]) + NBR_W'(ne[c]);
      life_row[c] = (nbr == life_pkg::BIRTH_COUNT) ||
                    (cur_row[c] && (nbr == life_pkg::SURVIVE_COUNT));
      col_mask[c] = (c < int'(cols_sz));
    end
  end

  assign merged_row = (cur_row & ~col_mask) | (life_row & col_mask);

  assign wr_en   = cmd.gen_row | cmd.cell_write;
  assign wr_addr = cmd.cell_write ? cell_row : row_idx;
  assign wr_data = cmd.cell_write ? cell_new : merged_row;

  // result register
  assign emit_row = (cmd.gen_row ? life_row : rd_row) & col_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.gen_row || cmd.dump_row) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_row || cmd.dump_row) begin
      result.row_number <= ROWN_W'(row_idx);
      result.row_cells  <= CELLS_W'(emit_row);
      result.last_row   <= status.last;
    end
  end

  // status
  assign status.func      = item_q.func;
  assign status.in_range  = (CFG_XW'(item_q.row_index) < rows_wide) &&
                            (CFG_XW'(item_q.col_index) < cols_wide);
  assign status.has_next  = (({1'b0, row_idx} + (RW+1)'(1)) < rows_sz);
  assign status.has_next2 = (({1'b0, row_idx} + (RW+1)'(2)) < rows_sz);
  assign status.last      = (({1'b0, row_idx} + (RW+1)'(1)) == rows_sz);
  assign status.out_free  = !result_valid || !result_stall;

endmodule

`default_nettype wire

// ===== design/life_automaton_torus_step.sv =====
// life_automaton_torus_step: top level of the toroidal b3/s23 life grid
// depends on life_pkg, life_ctrl, life_dpath, life_ram
//
// The block holds a grid of up to MAX_ROWS by MAX_COLS cells, all dead after
// reset, on a torus whose size in use comes from the row_count and col_count
// registers (0 acts as 1, values above the maximum act as the maximum). Each
// input word either sets one cell alive, sets one cell dead, advances one
// generation or dumps the grid; the last two send one result word per row in
// use, from row 0 up, with last_row marking the final one. Cell writes outside
// the size in use are dropped and give no result. Items are taken one at a
// time: a cell write passes through decode and a read-modify-write of its row
// (a write outside the torus ends at decode), a dump or generation sweeps the
// rows in use, and a row waits while the previous row word is held by a
// stalled result side. The generation sweep walks the single read port of the
// grid ram one row per cycle, while the result side does not stall, through a
// three-row window. The grid is cleared at reset by per-row valid bits, so
// there is no clearing pass. Size registers must only be written while no
// item is in progress.
`default_nettype none

module life_automaton_torus_step #(
  parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,

  // configuration write port
  input  wire logic                           cfg_wr_en,
  input  wire logic [life_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [life_pkg::CFG_W-1:0]     cfg_data,

  // item words
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire life_pkg::item_word_t           item,

  // result words, one per grid row
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output life_pkg::result_word_t              result
);

  // commands from the sequencer, status back from the datapath
  life_pkg::dp_cmd_t    cmd;
  life_pkg::dp_status_t status;

  // sequencer: item acceptance, decode, and the row sweeps
  life_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  // datapath: size registers, grid ram, row window, rule and result register
  life_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

`default_nettype wire
